// ===== src/sfis_pkg.sv =====
// Shared constants, types and register codes for the substring search unit.
package sfis_pkg;

    // Longest pattern held in the compare window
    localparam int PAT_MAX = 8;
    // Bytes of one string that take part in the search
    localparam longint MAX_TEXT = 65536;

    localparam int BYTE_W     = 8;
    localparam int PAT_W      = 64;
    localparam int LEN_W      = 4;
    localparam int INDEX_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    // Byte count saturates at MAX_TEXT, so it needs one bit above the position
    localparam int POS_W      = $clog2(MAX_TEXT);
    localparam int COUNT_W    = POS_W + 1;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } cfg_reg_t;

    // One text beat
    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              is_last;
    } item_t;

    // One search result
    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
    } result_t;

    // Newest byte in entry 0
    typedef logic [PAT_MAX-1:0][BYTE_W-1:0] window_t;

endpackage

// ===== src/sfis_in_reg.sv =====
// Input register stage holding one accepted text beat.
module sfis_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_valid,
    output logic           s_ready,
    input  sfis_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output sfis_pkg::item_t item
);
    import sfis_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept when empty or when the held beat moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Occupancy of the stage
    always_comb
    begin
        valid_next = valid_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on each accepted beat
    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== src/sfis_core.sv =====
// Byte window, parallel pattern compare and per-string match tracking.
module sfis_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sfis_pkg::PAT_W-1:0] pattern_bytes,
    input  logic [sfis_pkg::LEN_W-1:0] pattern_length,
    input  logic                      item_valid,
    input  sfis_pkg::item_t           item,
    input  logic                      out_space,
    output logic                      take,
    output logic                      res_valid,
    output sfis_pkg::result_t         res
);
    import sfis_pkg::*;

    window_t            win_reg;
    window_t            win_next;
    window_t            win_shift;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] seen_next;
    logic               match_reg;
    logic               match_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic [PAT_MAX-1:0] hit_len;
    logic               len_hit;
    logic               room;
    logic [COUNT_W-1:0] after_cnt;
    logic               long_enough;
    logic               record;
    logic [POS_W-1:0]   pos_new;

    // A last beat needs space in the result register; others always move
    assign take      = item_valid && (!item.is_last || out_space);
    assign res_valid = take && item.is_last;

    // Shift the new byte into the window
    always_comb
    begin
        win_shift[0] = item.text_byte;
        for (int k = 1; k < PAT_MAX; k++)
        begin
            win_shift[k] = win_reg[k-1];
        end
    end

    // Compare the newest l bytes against the pattern for every length l
    always_comb
    begin
        for (int l = 1; l <= PAT_MAX; l++)
        begin
            hit_len[l-1] = 1'b1;
            for (int i = 0; i < l; i++)
            begin
                if (win_shift[l-1-i] != pattern_bytes[i*BYTE_W +: BYTE_W])
                begin
                    hit_len[l-1] = 1'b0;
                end
            end
        end
    end

    // Pick the length in use; zero or too long never matches
    always_comb
    begin
        len_hit = 1'b0;
        for (int l = 1; l <= PAT_MAX; l++)
        begin
            if (pattern_length == LEN_W'(l))
            begin
                len_hit = hit_len[l-1];
            end
        end
    end

    assign room        = seen_reg < COUNT_W'(MAX_TEXT);
    assign after_cnt   = seen_reg + 1'b1;
    assign long_enough = after_cnt >= COUNT_W'(pattern_length);
    assign record      = room && !match_reg && len_hit && long_enough;
    assign pos_new     = POS_W'(after_cnt - COUNT_W'(pattern_length));

    // Result for a last beat: earlier match wins over one found now
    always_comb
    begin
        res.found       = match_reg || record;
        res.match_index = '0;
        if (match_reg)
        begin
            res.match_index = INDEX_W'(pos_reg);
        end
        else if (record)
        begin
            res.match_index = INDEX_W'(pos_new);
        end
    end

    // Advance the per-string state; clear it after the last beat
    always_comb
    begin
        win_next   = win_reg;
        seen_next  = seen_reg;
        match_next = match_reg;
        pos_next   = pos_reg;
        if (take)
        begin
            if (item.is_last)
            begin
                win_next   = '0;
                seen_next  = '0;
                match_next = 1'b0;
                pos_next   = '0;
            end
            else
            begin
                win_next = win_shift;
                if (room)
                begin
                    seen_next = after_cnt;
                end
                if (record)
                begin
                    match_next = 1'b1;
                    pos_next   = pos_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg   <= '0;
            seen_reg  <= '0;
            match_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            win_reg   <= win_next;
            seen_reg  <= seen_next;
            match_reg <= match_next;
            pos_reg   <= pos_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A finished string leaves no trace for the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        take && item.is_last |=> seen_reg == '0 && !match_reg && win_reg == '0)
    else $error("string state not cleared after last beat");

    // A recorded match holds until its string ends
    assert property (@(posedge clk) disable iff (!rst_n)
        match_reg && !(take && item.is_last) |=> match_reg && $stable(pos_reg))
    else $error("recorded match lost or moved mid-string");

    // Byte count never passes its saturation point
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= COUNT_W'(MAX_TEXT))
    else $error("byte count beyond saturation");

    // A match start lies inside the bytes counted so far
    assert property (@(posedge clk) disable iff (!rst_n)
        match_reg |-> COUNT_W'(pos_reg) < seen_reg)
    else $error("match position beyond bytes seen");
`endif

endmodule

// ===== src/sfis_out_reg.sv =====
// Result register feeding the output stream.
module sfis_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  sfis_pkg::result_t  res,
    output logic               space,
    output logic               m_valid,
    input  logic               m_ready,
    output sfis_pkg::result_t  m_res
);
    import sfis_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Room when empty or when the held result leaves this cycle
    assign space   = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    // Hold until taken, reload on a new result
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== src/substring_first_index_search_unit.sv =====
// Top level of the first-occurrence substring search unit.
//
//  channel   direction  payload
//  s_axis    in         tdata[7:0] text_byte, tlast is_last
//  m_axis    out        tdata[15:0] match_index, tuser found
//  cfg       in         cfg_index register, cfg_data value
//
// One text byte is accepted every cycle unless a last byte is held waiting
// for space in the result register. A last byte passes from the input
// register through the full window compare into the result register, which
// drives tvalid.
// Reset clears the pattern registers, the byte window and the string state.
// A stalled result holds a following last byte in the input register, and the
// bytes behind it wait; other bytes keep flowing.
module substring_first_index_search_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sfis_pkg::INDEX_W-1:0]      m_axis_tdata,  // [15:0] match_index
    output logic                              m_axis_tuser,  // [0] found
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfis_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sfis_pkg::*;

    logic [PAT_W-1:0] pat_bytes_reg;
    logic [LEN_W-1:0] pat_len_reg;
    logic [PAT_W-1:0] pat_bytes_next;
    logic [LEN_W-1:0] pat_len_next;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    take;
    logic    res_valid;
    result_t res;
    logic    out_space;
    result_t m_res;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        pat_bytes_next = pat_bytes_reg;
        pat_len_next   = pat_len_reg;
        if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PATTERN_BYTES:  pat_bytes_next = cfg_data[PAT_W-1:0];
                REG_PATTERN_LENGTH: pat_len_next   = cfg_data[LEN_W-1:0];
                default:            pat_len_next   = pat_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
        end
        else
        begin
            pat_bytes_reg <= pat_bytes_next;
            pat_len_reg   <= pat_len_next;
        end
    end

    // Pack the input beat
    assign s_item.text_byte = s_axis_tdata;
    assign s_item.is_last   = s_axis_tlast;

    sfis_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    sfis_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .pattern_bytes  (pat_bytes_reg),
        .pattern_length (pat_len_reg),
        .item_valid     (item_valid),
        .item           (item),
        .out_space      (out_space),
        .take           (take),
        .res_valid      (res_valid),
        .res            (res)
    );

    sfis_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (res_valid),
        .res     (res),
        .space   (out_space),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res)
    );

    // Unpack the result beat
    assign m_axis_tdata = m_res.match_index;
    assign m_axis_tuser = m_res.found;

endmodule
